[hw/rtl/scancode_to_ascii_fifo_unit_assert.svh]
// Assertion macros for the scancode decoder RTL.
// No dependencies; included by the top level, the only module that checks itself.
`ifndef SCANCODE_TO_ASCII_FIFO_UNIT_ASSERT_SVH
`define SCANCODE_TO_ASCII_FIFO_UNIT_ASSERT_SVH
`ifndef SYNTH
// check with reset masking
`define SCTA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("scta assertion failed");
// check that also holds through reset
`define SCTA_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("scta reset assertion failed");
`else
`define SCTA_ASSERT(lbl, clk, rstn, prop)
`define SCTA_ASSERT_RST(lbl, clk, prop)
`endif
`endif

[hw/rtl/scta_pkg.sv]
// Package for the scancode decoder: constants, the set-1 ASCII map and the keymap type.
// No dependencies.
`timescale 1ns / 1ps

package scta_pkg;

    localparam int BUFFER_DEPTH_DEF = 128;
    localparam int TABLE_LEN        = 58;

    localparam logic [7:0] REL_BIT     = 8'h80;
    localparam logic [7:0] CODE_MASK   = 8'h7F;
    localparam logic [7:0] SHIFT_LEFT  = 8'h2A;
    localparam logic [7:0] SHIFT_RIGHT = 8'h36;
    localparam logic [7:0] CASE_GAP    = 8'd32;

    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_READ = 1'b1;

    // set-1 make code -> ASCII, zero where no character
    localparam logic [7:0] ASCII_MAP [0:TABLE_LEN-1] = '{
        8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
        8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
        8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
    };

    typedef struct packed {
        logic       push;      // a character comes out of this byte
        logic [7:0] ch;
        logic       shift_set;
        logic       shift_clr;
    } keymap_t;

endpackage

[hw/rtl/scancode_to_ascii_fifo_unit.sv]
// Top level of the set-1 scancode decoder with its character ring.
// Depends on scta_pkg, scta_keymap, scta_char_ram and the assertion header.
//
// Usage:
//   Input channel (s_valid/s_ready): s_op = 0 delivers a raw scancode byte in
//   s_scan_byte, s_op = 1 asks for the oldest buffered character.
//   Result channel (m_valid/m_ready): one word per input word, in order, with
//   m_char_valid/m_char_out (popped character), m_has_data (ring not empty
//   after the word) and m_dropped (decoded character lost on a full ring).
//   Pipeline: the accepting edge decodes, updates the pointers and captures the
//   ring read into the stage; the output register loads from the stage when it
//   is empty or m_ready is high.
//   Throughput: one word per cycle while m_ready stays high; the single-port
//   ring read and the one-entry stage in front of the output register set it.
//   The ring holds BUFFER_DEPTH-1 characters.
//   Reset: pointers, shift state and both valid flags clear; the ring contents
//   are left as they are and never read before they are written.
//   Stall: with m_ready low the output register holds, the stage behind it
//   fills, and s_ready drops until the result is taken.
`timescale 1ns / 1ps
`include "scancode_to_ascii_fifo_unit_assert.svh"

module scancode_to_ascii_fifo_unit #(
    parameter int BUFFER_DEPTH = scta_pkg::BUFFER_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_op,
    input  logic [7:0] s_scan_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_char_valid,
    output logic [7:0] m_char_out,
    output logic       m_has_data,
    output logic       m_dropped
);
    import scta_pkg::*;

    localparam int PTR_W = $clog2(BUFFER_DEPTH);
    localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(BUFFER_DEPTH - 1);

    keymap_t    km;
    logic [7:0] rd_data;

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_adv, rd_adv;
    logic             shift_reg, shift_next;

    // decode stage, waiting on the ring read
    logic stg_valid_reg, stg_valid_next;
    logic stg_pop_reg, stg_has_data_reg, stg_dropped_reg;

    logic       m_valid_reg, m_valid_next;
    logic       m_char_valid_reg, m_has_data_reg, m_dropped_reg;
    logic [7:0] m_char_out_reg;

    logic accept, is_read, not_empty, full;
    logic pop, push_req, push, drop, out_load;

    scta_keymap u_keymap (
        .scan_byte  (s_scan_byte),
        .shift_held (shift_reg),
        .km         (km)
    );

    scta_char_ram #(
        .DEPTH  (BUFFER_DEPTH),
        .ADDR_W (PTR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (push),
        .wr_addr (wr_ptr_reg),
        .wr_data (km.ch),
        .rd_en   (pop),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_data)
    );

    always_comb begin
        out_load  = stg_valid_reg && (!m_valid_reg || m_ready);
        s_ready   = !stg_valid_reg || out_load;
        accept    = s_valid && s_ready;
        is_read   = (s_op == OP_READ);

        wr_adv    = (wr_ptr_reg == LAST_POS) ? '0 : wr_ptr_reg + 1'b1;
        rd_adv    = (rd_ptr_reg == LAST_POS) ? '0 : rd_ptr_reg + 1'b1;
        not_empty = (wr_ptr_reg != rd_ptr_reg);
        full      = (wr_adv == rd_ptr_reg);

        pop      = accept && is_read && not_empty;
        push_req = accept && !is_read && km.push;
        push     = push_req && !full;
        drop     = push_req && full;

        wr_ptr_next = push ? wr_adv : wr_ptr_reg;
        rd_ptr_next = pop ? rd_adv : rd_ptr_reg;

        shift_next = shift_reg;
        if (accept && !is_read) begin
            if (km.shift_set) begin
                shift_next = 1'b1;
            end else if (km.shift_clr) begin
                shift_next = 1'b0;
            end
        end

        if (accept) begin
            stg_valid_next = 1'b1;
        end else if (out_load) begin
            stg_valid_next = 1'b0;
        end else begin
            stg_valid_next = stg_valid_reg;
        end

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            shift_reg     <= 1'b0;
            stg_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            shift_reg     <= shift_next;
            stg_valid_reg <= stg_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            stg_pop_reg      <= pop;
            stg_has_data_reg <= (wr_ptr_next != rd_ptr_next);
            stg_dropped_reg  <= drop;
        end
        if (out_load) begin
            m_char_valid_reg <= stg_pop_reg;
            m_char_out_reg   <= stg_pop_reg ? rd_data : 8'h00;
            m_has_data_reg   <= stg_has_data_reg;
            m_dropped_reg    <= stg_dropped_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_char_valid = m_char_valid_reg;
    assign m_char_out   = m_char_out_reg;
    assign m_has_data   = m_has_data_reg;
    assign m_dropped    = m_dropped_reg;

    `SCTA_ASSERT_RST(a_reset_clears, aclk, !aresetn |=> !m_valid_reg && !stg_valid_reg)
    `SCTA_ASSERT(a_pop_xor_drop, aclk, aresetn, m_valid_reg |-> !(m_char_valid_reg && m_dropped_reg))
    `SCTA_ASSERT(a_drop_has_data, aclk, aresetn, m_valid_reg && m_dropped_reg |-> m_has_data_reg)
    `SCTA_ASSERT(a_push_fills, aclk, aresetn, push |=> wr_ptr_reg != rd_ptr_reg)
    `SCTA_ASSERT(a_stage_holds, aclk, aresetn, stg_valid_reg && !out_load |=> stg_valid_reg && $stable(stg_pop_reg))

endmodule

[hw/rtl/scta_char_ram.sv]
// Character ring storage: one write port, one registered read port.
// Depends on nothing; sized by the top level.
`timescale 1ns / 1ps

module scta_char_ram #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [0:DEPTH-1];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/scta_keymap.sv]
// Scancode byte decode: table lookup, shift casing and shift key detection.
// Depends on scta_pkg.
`timescale 1ns / 1ps

module scta_keymap (
    input  logic             [7:0] scan_byte,
    input  logic                   shift_held,
    output scta_pkg::keymap_t      km
);
    import scta_pkg::*;

    logic [7:0] code7;
    logic [7:0] raw_ch;
    logic       in_table;

    always_comb begin
        code7    = scan_byte & CODE_MASK;
        in_table = ((scan_byte & REL_BIT) == 8'h00) && (scan_byte < 8'(TABLE_LEN));
        raw_ch   = in_table ? ASCII_MAP[scan_byte[5:0]] : 8'h00;

        km.push = (raw_ch != 8'h00);
        if (shift_held && (raw_ch inside {[8'h61:8'h7A]})) begin
            km.ch = raw_ch - CASE_GAP;
        end else begin
            km.ch = raw_ch;
        end

        km.shift_set = ((scan_byte & REL_BIT) == 8'h00)
                       && (code7 == SHIFT_LEFT || code7 == SHIFT_RIGHT);
        km.shift_clr = ((scan_byte & REL_BIT) != 8'h00)
                       && (code7 == SHIFT_LEFT || code7 == SHIFT_RIGHT);
    end

endmodule

[tb/tb_scancode_to_ascii_fifo_unit.sv]
// Self-checking testbench for scancode_to_ascii_fifo_unit: set-1 decode, shift, ring fill/drain.
// Depends on scta_pkg and the RTL top; the expected words come from a local keyboard/ring model.
`timescale 1ns / 1ps

module tb_scancode_to_ascii_fifo_unit;

    localparam int RING_DEPTH  = scta_pkg::BUFFER_DEPTH_DEF;
    localparam int KEYMAP_LEN  = 58;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_TAIL  = 8;

    localparam logic [7:0] KEY_LSHIFT  = 8'h2A;
    localparam logic [7:0] KEY_RSHIFT  = 8'h36;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    localparam logic [7:0] KEYMAP [0:KEYMAP_LEN-1] = '{
        8'h00, 8'h00, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=", 8'h08,
        8'h09, "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]", 8'h0A,
        8'h00, "a", "s", "d", "f", "g", "h", "j", "k", "l", ";", 8'h27, 8'h60, 8'h00,
        8'h5C, "z", "x", "c", "v", "b", "n", "m", ",", ".", "/", 8'h00, "*", 8'h00, " "
    };

    typedef struct packed {
        logic       char_valid;
        logic [7:0] char_out;
        logic       has_data;
        logic       dropped;
    } key_reply_t;

    typedef struct {
        logic       op;
        logic [7:0] code;
        bit         typed;
        key_reply_t reply;
    } dir_row_t;

    localparam int NUM_DIR = 26;

    // typed rows: reply is obvious without running the ring model
    dir_row_t dir_rows [0:NUM_DIR-1] = '{
        '{scta_pkg::OP_READ, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0}},
        '{scta_pkg::OP_SCAN, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0}},
        '{scta_pkg::OP_SCAN, 8'h3A, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0}},
        '{scta_pkg::OP_SCAN, 8'h7F, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0}},
        '{scta_pkg::OP_SCAN, 8'hFF, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0}},
        '{scta_pkg::OP_SCAN, 8'h1E, 1'b0, '0},
        '{scta_pkg::OP_SCAN, 8'h2A, 1'b0, '0},
        '{scta_pkg::OP_SCAN, 8'h1E, 1'b0, '0},
        '{scta_pkg::OP_SCAN, 8'h02, 1'b0, '0},
        '{scta_pkg::OP_SCAN, 8'hAA, 1'b0, '0},
        '{scta_pkg::OP_SCAN, 8'h2C, 1'b0, '0},
        '{scta_pkg::OP_SCAN, 8'h36, 1'b0, '0},
        '{scta_pkg::OP_SCAN, 8'h10, 1'b0, '0},
        '{scta_pkg::OP_SCAN, 8'h9E, 1'b0, '0},
        '{scta_pkg::OP_SCAN, 8'h32, 1'b0, '0},
        '{scta_pkg::OP_SCAN, 8'hB6, 1'b0, '0},
        '{scta_pkg::OP_SCAN, 8'h39, 1'b0, '0},
        '{scta_pkg::OP_SCAN, 8'h80, 1'b0, '0},
        '{scta_pkg::OP_READ, 8'hFF, 1'b0, '0},
        '{scta_pkg::OP_READ, 8'h00, 1'b0, '0},
        '{scta_pkg::OP_READ, 8'h00, 1'b0, '0},
        '{scta_pkg::OP_READ, 8'h00, 1'b0, '0},
        '{scta_pkg::OP_READ, 8'h00, 1'b0, '0},
        '{scta_pkg::OP_READ, 8'h00, 1'b0, '0},
        '{scta_pkg::OP_READ, 8'h00, 1'b0, '0},
        '{scta_pkg::OP_READ, 8'h55, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0}}
    };

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic       s_op;
    logic [7:0] s_scan_byte;
    logic       m_valid;
    logic       m_ready;
    logic       m_char_valid;
    logic [7:0] m_char_out;
    logic       m_has_data;
    logic       m_dropped;

    // local copy of the keyboard/ring state
    logic [7:0] ring_mirror [0:RING_DEPTH-1];
    int         wr_idx;
    int         rd_idx;
    logic       shift_down;

    key_reply_t pending_replies [$];
    int         err_count;
    int         idle_cycles;
    int         rx_stall_pct;
    int         words_sent;
    int         n_popped;
    int         n_dropped;
    int         n_empty_reads;
    int         n_upper;

    scancode_to_ascii_fifo_unit u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_scan_byte  (s_scan_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_char_valid (m_char_valid),
        .m_char_out   (m_char_out),
        .m_has_data   (m_has_data),
        .m_dropped    (m_dropped)
    );

    initial begin
        aclk = 1'b0;
    end

    always #1 aclk = ~aclk;

    function automatic int ring_next(input int p);
        return (p + 1 == RING_DEPTH) ? 0 : p + 1;
    endfunction

    task automatic note_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic decode_word(input logic op, input logic [7:0] code, output key_reply_t r);
        logic [7:0] ch;
        r = '0;
        if (op == scta_pkg::OP_READ) begin
            if (wr_idx != rd_idx) begin
                r.char_valid = 1'b1;
                r.char_out   = ring_mirror[rd_idx];
                rd_idx       = ring_next(rd_idx);
                n_popped++;
            end else begin
                n_empty_reads++;
            end
        end else if (!code[7]) begin
            if (code < KEYMAP_LEN) begin
                ch = KEYMAP[code];
                if (ch != 8'h00) begin
                    if (shift_down && ch >= "a" && ch <= "z") begin
                        ch = ch - CASE_OFFSET;
                        n_upper++;
                    end
                    if (ring_next(wr_idx) != rd_idx) begin
                        ring_mirror[wr_idx] = ch;
                        wr_idx = ring_next(wr_idx);
                    end else begin
                        r.dropped = 1'b1;
                        n_dropped++;
                    end
                end
            end
            if (code == KEY_LSHIFT || code == KEY_RSHIFT) shift_down = 1'b1;
        end else if (code[6:0] == KEY_LSHIFT[6:0] || code[6:0] == KEY_RSHIFT[6:0]) begin
            shift_down = 1'b0;
        end
        r.has_data = (wr_idx != rd_idx);
    endtask

    // drive one word at a falling edge, hold it until the rising edge that takes it
    task automatic send_word(input logic op, input logic [7:0] code, input int idle_pct,
                             input bit typed, input key_reply_t typed_reply);
        key_reply_t predicted;
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_op        = op;
        s_scan_byte = code;
        do @(posedge aclk); while (!s_ready);
        decode_word(op, code, predicted);
        pending_replies.push_back(typed ? typed_reply : predicted);
        words_sent++;
    endtask

    // mostly plausible keyboard traffic, with some raw noise bytes
    task automatic pick_word(input int read_pct, output logic op, output logic [7:0] code);
        int r;
        if ($urandom_range(99) < read_pct) begin
            op   = scta_pkg::OP_READ;
            code = 8'($urandom);
        end else begin
            op = scta_pkg::OP_SCAN;
            r  = $urandom_range(99);
            if (r < 60) begin
                code = 8'($urandom_range(KEYMAP_LEN - 1));
            end else if (r < 72) begin
                case ($urandom_range(3))
                    0: code = KEY_LSHIFT;
                    1: code = KEY_RSHIFT;
                    2: code = KEY_LSHIFT | 8'h80;
                    default: code = KEY_RSHIFT | 8'h80;
                endcase
            end else if (r < 85) begin
                code = 8'h80 | 8'($urandom_range(127));
            end else begin
                code = 8'($urandom_range(255));
            end
        end
    endtask

    task automatic run_phase(input int count, input int read_pct, input int idle_pct,
                             input int stall_pct);
        logic       op;
        logic [7:0] code;
        rx_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            pick_word(read_pct, op, code);
            send_word(op, code, idle_pct, 1'b0, '0);
        end
    endtask

    task automatic hold_until_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        wait (pending_replies.size() == 0);
    endtask

    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        key_reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_replies.size() == 0) begin
                note_error("result word with nothing pending");
            end else begin
                want = pending_replies.pop_front();
                if (m_char_valid !== want.char_valid)
                    note_error($sformatf("char_valid %b, want %b", m_char_valid, want.char_valid));
                if (m_char_out !== want.char_out)
                    note_error($sformatf("char_out %h, want %h", m_char_out, want.char_out));
                if (m_has_data !== want.has_data)
                    note_error($sformatf("has_data %b, want %b", m_has_data, want.has_data));
                if (m_dropped !== want.dropped)
                    note_error($sformatf("dropped %b, want %b", m_dropped, want.dropped));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no word moved in %0d cycles", STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_op          = scta_pkg::OP_SCAN;
        s_scan_byte   = 8'h00;
        m_ready       = 1'b0;
        rx_stall_pct  = 0;
        err_count     = 0;
        idle_cycles   = 0;
        words_sent    = 0;
        n_popped      = 0;
        n_dropped     = 0;
        n_empty_reads = 0;
        n_upper       = 0;
        wr_idx        = 0;
        rd_idx        = 0;
        shift_down    = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < NUM_DIR; i++) begin
            send_word(dir_rows[i].op, dir_rows[i].code, 0, dir_rows[i].typed,
                      dir_rows[i].reply);
        end

        run_phase(300, 3, 0, 0);      // fills the ring, pushes past full
        run_phase(150, 70, 86, 0);
        hold_until_drained();
        run_phase(150, 50, 0, 86);
        run_phase(150, 5, 19, 19);
        run_phase(100, 70, 0, 0);

        @(negedge aclk);
        s_valid      = 1'b0;
        rx_stall_pct = 0;
        wait (pending_replies.size() == 0);
        repeat (DRAIN_TAIL) @(posedge aclk);

        $display("Sent %0d words: %0d characters read back (%0d shifted to upper case),",
                 words_sent, n_popped, n_upper);
        $display("%0d characters lost on a full ring, %0d reads of an empty ring.",
                 n_dropped, n_empty_reads);
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
